>>> design/operating_mode_command_gate_macros.svh
`ifndef OPERATING_MODE_COMMAND_GATE_MACROS_SVH
`define OPERATING_MODE_COMMAND_GATE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OMCG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("omcg same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define OMCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("omcg next-cycle check failed");

`endif

>>> design/omcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package omcg_pkg;

  typedef enum logic [2:0] {
    MODE_INIT       = 3'd0,
    MODE_IDLE       = 3'd1,
    MODE_WASHING    = 3'd2,
    MODE_MANUAL     = 3'd3,
    MODE_SELFCHECK  = 3'd4,
    MODE_EXCEPTION  = 3'd5,
    MODE_RECOVERING = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    OP_COMMAND        = 4'd0,
    OP_INIT           = 4'd1,
    OP_WASH_START     = 4'd2,
    OP_WASH_DONE      = 4'd3,
    OP_WASH_ABORT     = 4'd4,
    OP_POST_WASH      = 4'd5,
    OP_SELFCHECK_DONE = 4'd6,
    OP_CRITICAL       = 4'd7,
    OP_ESTOP_ON       = 4'd8,
    OP_ESTOP_OFF      = 4'd9,
    OP_RECOVERY_DONE  = 4'd10,
    OP_LEGACY_RESET   = 4'd11,
    OP_SET_SERVICE    = 4'd12
  } op_t;

  typedef enum logic [3:0] {
    CMD_START_WASH     = 4'd1,
    CMD_STOP_WASH      = 4'd2,
    CMD_STOP_OP        = 4'd3,
    CMD_RESUME         = 4'd4,
    CMD_RESET_FAULT    = 4'd5,
    CMD_HOME           = 4'd6,
    CMD_ENTER_MANUAL   = 4'd7,
    CMD_MANUAL_ACT     = 4'd8,
    CMD_SELF_CHECK     = 4'd9,
    CMD_RECOVER        = 4'd10,
    CMD_STOP_OUTPUTS   = 4'd11
  } cmd_t;

  typedef enum logic [2:0] {
    RSN_NONE         = 3'd0,
    RSN_UNKNOWN_CMD  = 3'd1,
    RSN_WRONG_MODE   = 3'd2,
    RSN_ESTOP        = 3'd3,
    RSN_SERVICE_OFF  = 3'd4
  } reason_t;

  typedef enum logic [2:0] {
    EFF_NONE         = 3'd0,
    EFF_START_WASH   = 3'd1,
    EFF_STOP_WASH    = 3'd2,
    EFF_SELF_CHECK   = 3'd3,
    EFF_RESET_FAULT  = 3'd4,
    EFF_HOME         = 3'd5,
    EFF_MANUAL_ACT   = 3'd6,
    EFF_STOP_OUTPUTS = 3'd7
  } effect_t;

  typedef enum logic [1:0] {
    PERM_NO = 2'd0,
    PERM_OK = 2'd1,
    PERM_IF = 2'd2
  } perm_t;

  typedef struct packed {
    logic [3:0] operation;
    logic [3:0] command_kind;
    logic       event_flag;
    logic       alarm_blocking;
    logic       safety_lockout;
  } item_t;

  typedef struct packed {
    mode_t mode;
    logic  estop;
    logic  service;
  } state_t;

  typedef struct packed {
    logic    cmd_rejected;
    reason_t reject_reason;
    effect_t effect_code;
    mode_t   mode_now;
    mode_t   mode_before;
    logic    mode_changed;
    logic    recovery_requested;
    logic    context_sync;
    logic    estop_latched;
    logic    service_on;
    logic    stopping;
    logic    standby;
  } result_t;

  // Permission matrix, command kind by mode. Unknown kinds fall to the default and get PERM_NO.
  function automatic perm_t perm_lookup(input logic [3:0] kind, input mode_t mode);
    perm_t p;
    p = PERM_NO;
    case (kind)
      CMD_START_WASH, CMD_STOP_OP, CMD_RESUME, CMD_ENTER_MANUAL:
        if (mode == MODE_IDLE) p = PERM_OK;
      CMD_STOP_WASH:
        if (mode == MODE_WASHING) p = PERM_OK;
      CMD_RESET_FAULT, CMD_SELF_CHECK:
        if (mode == MODE_IDLE || mode == MODE_EXCEPTION) p = PERM_IF;
      CMD_HOME:
        if (mode == MODE_EXCEPTION) p = PERM_OK;
      CMD_MANUAL_ACT:
        if (mode == MODE_MANUAL || mode == MODE_EXCEPTION) p = PERM_OK;
      CMD_RECOVER:
        if (mode == MODE_MANUAL || mode == MODE_EXCEPTION) p = PERM_IF;
      CMD_STOP_OUTPUTS:
        if (mode != MODE_INIT && mode != MODE_SELFCHECK) p = PERM_OK;
      default:
        p = PERM_NO;
    endcase
    return p;
  endfunction

  function automatic effect_t effect_lookup(input logic [3:0] kind);
    effect_t e;
    case (kind)
      CMD_START_WASH:   e = EFF_START_WASH;
      CMD_STOP_WASH:    e = EFF_STOP_WASH;
      CMD_RESET_FAULT:  e = EFF_RESET_FAULT;
      CMD_HOME:         e = EFF_HOME;
      CMD_MANUAL_ACT:   e = EFF_MANUAL_ACT;
      CMD_SELF_CHECK:   e = EFF_SELF_CHECK;
      CMD_STOP_OUTPUTS: e = EFF_STOP_OUTPUTS;
      default:          e = EFF_NONE;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

>>> design/operating_mode_command_gate.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Accepted when                    Payload
// s_axis    in         s_axis_tvalid && s_axis_tready    tuser: operation; tdata: rest
// m_axis    out        m_axis_tvalid && m_axis_tready    tdata: one result item
//
// Each item passes an input register, then the combinational decision logic into
// the result register; the mode and flags update as the item enters that register.
// The result is registered; one item per cycle sustained while m_axis_tready is high.
// A stall on m_axis holds the result register; the input register still takes one
// more item. rst is synchronous: mode init, estop clear, service enabled, both stages empty.

`include "operating_mode_command_gate_macros.svh"

module operating_mode_command_gate (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] command_kind, [4] event_flag, [5] alarm_blocking, [6] safety_lockout, [7] zero
  input  wire logic [7:0]  s_axis_tdata,
  // [3:0] operation
  input  wire logic [3:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] cmd_rejected, [3:1] reject_reason, [6:4] effect_code, [9:7] mode_now,
  // [12:10] mode_before, [13] mode_changed, [14] recovery_requested,
  // [15] context_sync, [16] estop_latched, [17] service_on, [18] stopping,
  // [19] standby, [23:20] zero
  output logic [23:0]      m_axis_tdata
);

  omcg_pkg::item_t   in_item;
  logic              in_valid;
  omcg_pkg::state_t  state;
  omcg_pkg::state_t  state_next;
  omcg_pkg::result_t res_next;
  omcg_pkg::result_t res;
  logic              out_free;
  logic              advance;
  logic              accept;
  logic              res_matches_state;
  logic              reject_is_clean;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  omcg_step u_step (
    .item       (in_item),
    .state      (state),
    .result     (res_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      state.mode    <= omcg_pkg::MODE_INIT;
      state.estop   <= 1'b0;
      state.service <= 1'b1;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        state         <= state_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.operation      <= s_axis_tuser;
      in_item.command_kind   <= s_axis_tdata[3:0];
      in_item.event_flag     <= s_axis_tdata[4];
      in_item.alarm_blocking <= s_axis_tdata[5];
      in_item.safety_lockout <= s_axis_tdata[6];
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {4'd0, res.standby, res.stopping, res.service_on,
                         res.estop_latched, res.context_sync, res.recovery_requested,
                         res.mode_changed, res.mode_before, res.mode_now,
                         res.effect_code, res.reject_reason, res.cmd_rejected};

  assign res_matches_state = (res.mode_now == state.mode) &&
                             (res.estop_latched == state.estop) &&
                             (res.service_on == state.service);
  assign reject_is_clean   = (res.effect_code == omcg_pkg::EFF_NONE) &&
                             (res.mode_now == res.mode_before) && !res.context_sync;

  // The held result always mirrors the state it left behind.
  `OMCG_ASSERT_NOW(a_result_tracks_state, m_axis_tvalid, res_matches_state)
  `OMCG_ASSERT_NOW(a_reject_no_effect, m_axis_tvalid && res.cmd_rejected, reject_is_clean)
  `OMCG_ASSERT_NOW(a_standby_excl_stopping, m_axis_tvalid, !(res.standby && res.stopping))
  `OMCG_ASSERT_NEXT(a_advance_fills_output, advance, m_axis_tvalid)

endmodule

`default_nettype wire

>>> design/omcg_step.sv
`timescale 1ns / 1ps
`default_nettype none

module omcg_step (
  input  omcg_pkg::item_t   item,
  input  omcg_pkg::state_t  state,
  output omcg_pkg::result_t result,
  output omcg_pkg::state_t  state_next
);

  omcg_pkg::reason_t reason;
  omcg_pkg::perm_t   perm;
  omcg_pkg::mode_t   mode_nxt;
  logic              est_nxt;
  logic              svc_nxt;
  logic              direct;
  logic              sync;
  logic              recov;
  logic              rejected;
  omcg_pkg::effect_t effect;

  assign perm = omcg_pkg::perm_lookup(item.command_kind, state.mode);

  always_comb begin
    reason = omcg_pkg::RSN_NONE;
    if (item.command_kind == 4'd0 || item.command_kind > omcg_pkg::CMD_STOP_OUTPUTS) begin
      reason = omcg_pkg::RSN_UNKNOWN_CMD;
    end else if (perm == omcg_pkg::PERM_NO) begin
      reason = omcg_pkg::RSN_WRONG_MODE;
    end else if (perm == omcg_pkg::PERM_IF && state.estop) begin
      reason = omcg_pkg::RSN_ESTOP;
    end else if (item.command_kind == omcg_pkg::CMD_RESET_FAULT &&
                 state.mode == omcg_pkg::MODE_IDLE &&
                 !item.alarm_blocking && !item.safety_lockout) begin
      // Resetting a fault from idle needs something to reset.
      reason = omcg_pkg::RSN_WRONG_MODE;
    end else if (item.command_kind == omcg_pkg::CMD_START_WASH && !state.service) begin
      reason = omcg_pkg::RSN_SERVICE_OFF;
    end else if (item.command_kind == omcg_pkg::CMD_START_WASH && item.alarm_blocking) begin
      reason = omcg_pkg::RSN_WRONG_MODE;
    end else if (item.command_kind == omcg_pkg::CMD_RESUME && state.service) begin
      reason = omcg_pkg::RSN_WRONG_MODE;
    end
  end

  always_comb begin
    mode_nxt = state.mode;
    est_nxt  = state.estop;
    svc_nxt  = state.service;
    direct   = 1'b0;
    sync     = 1'b0;
    recov    = 1'b0;
    rejected = 1'b0;
    effect   = omcg_pkg::EFF_NONE;
    case (omcg_pkg::op_t'(item.operation))
      omcg_pkg::OP_COMMAND: begin
        if (reason != omcg_pkg::RSN_NONE) begin
          rejected = 1'b1;
        end else begin
          effect = omcg_pkg::effect_lookup(item.command_kind);
          case (item.command_kind)
            omcg_pkg::CMD_ENTER_MANUAL: mode_nxt = omcg_pkg::MODE_MANUAL;
            omcg_pkg::CMD_SELF_CHECK:   mode_nxt = omcg_pkg::MODE_SELFCHECK;
            omcg_pkg::CMD_RECOVER: begin
              mode_nxt = omcg_pkg::MODE_RECOVERING;
              recov    = 1'b1;
            end
            omcg_pkg::CMD_STOP_OP: begin
              svc_nxt = 1'b0;
              sync    = 1'b1;
            end
            omcg_pkg::CMD_RESUME: begin
              svc_nxt = 1'b1;
              sync    = 1'b1;
            end
            default: ;
          endcase
        end
      end
      omcg_pkg::OP_INIT: begin
        mode_nxt = omcg_pkg::MODE_IDLE;
        est_nxt  = 1'b0;
        svc_nxt  = 1'b1;
        direct   = 1'b1;
      end
      omcg_pkg::OP_WASH_START:
        if (state.mode == omcg_pkg::MODE_IDLE) mode_nxt = omcg_pkg::MODE_WASHING;
      omcg_pkg::OP_WASH_DONE:
        if (state.mode == omcg_pkg::MODE_WASHING) mode_nxt = omcg_pkg::MODE_IDLE;
      omcg_pkg::OP_WASH_ABORT:
        if (state.mode == omcg_pkg::MODE_WASHING) begin
          mode_nxt = item.event_flag ? omcg_pkg::MODE_IDLE : omcg_pkg::MODE_EXCEPTION;
        end
      omcg_pkg::OP_POST_WASH:
        if (state.mode == omcg_pkg::MODE_IDLE && item.event_flag) begin
          mode_nxt = omcg_pkg::MODE_EXCEPTION;
        end
      omcg_pkg::OP_SELFCHECK_DONE:
        if (state.mode == omcg_pkg::MODE_SELFCHECK) begin
          mode_nxt = item.event_flag ? omcg_pkg::MODE_EXCEPTION : omcg_pkg::MODE_IDLE;
        end
      omcg_pkg::OP_CRITICAL:
        if (state.mode != omcg_pkg::MODE_WASHING &&
            state.mode != omcg_pkg::MODE_RECOVERING) begin
          mode_nxt = omcg_pkg::MODE_EXCEPTION;
        end
      omcg_pkg::OP_ESTOP_ON: begin
        est_nxt  = 1'b1;
        mode_nxt = omcg_pkg::MODE_EXCEPTION;
      end
      omcg_pkg::OP_ESTOP_OFF: begin
        est_nxt = 1'b0;
        sync    = 1'b1;
      end
      omcg_pkg::OP_RECOVERY_DONE:
        if (state.mode == omcg_pkg::MODE_RECOVERING) begin
          mode_nxt = item.event_flag ? omcg_pkg::MODE_IDLE : omcg_pkg::MODE_EXCEPTION;
        end
      omcg_pkg::OP_LEGACY_RESET:
        if (state.mode == omcg_pkg::MODE_EXCEPTION) mode_nxt = omcg_pkg::MODE_IDLE;
      omcg_pkg::OP_SET_SERVICE: begin
        svc_nxt = item.event_flag;
        sync    = 1'b1;
      end
      default: ;
    endcase
  end

  assign state_next.mode    = mode_nxt;
  assign state_next.estop   = est_nxt;
  assign state_next.service = svc_nxt;

  always_comb begin
    result.cmd_rejected       = rejected;
    result.reject_reason      = rejected ? reason : omcg_pkg::RSN_NONE;
    result.effect_code        = effect;
    result.mode_now           = mode_nxt;
    result.mode_before        = state.mode;
    result.mode_changed       = !direct && (mode_nxt != state.mode);
    result.recovery_requested = recov;
    result.context_sync       = sync;
    result.estop_latched      = est_nxt;
    result.service_on         = svc_nxt;
    result.stopping           = !svc_nxt || mode_nxt == omcg_pkg::MODE_INIT ||
                                mode_nxt == omcg_pkg::MODE_EXCEPTION ||
                                mode_nxt == omcg_pkg::MODE_RECOVERING;
    result.standby            = (mode_nxt == omcg_pkg::MODE_IDLE) && svc_nxt;
  end

endmodule

`default_nettype wire

>>> sim/omcg_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the mode gate, tracks the mode and the two flags
// on its own, and checks every result item against the oldest prediction.
module omcg_result_checker
  import omcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [3:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          mismatch_count,
  output int          awaiting
);

  mode_t   gate_mode;
  logic    estop_on;
  logic    service_en;
  result_t expected_results[$];

  // Access level of each known command in each mode.
  perm_t   access_map [1:11][0:6];
  effect_t effect_of [1:11];

  initial begin
    access_map[CMD_START_WASH]   = '{PERM_NO, PERM_OK, PERM_NO, PERM_NO, PERM_NO, PERM_NO, PERM_NO};
    access_map[CMD_STOP_WASH]    = '{PERM_NO, PERM_NO, PERM_OK, PERM_NO, PERM_NO, PERM_NO, PERM_NO};
    access_map[CMD_STOP_OP]      = '{PERM_NO, PERM_OK, PERM_NO, PERM_NO, PERM_NO, PERM_NO, PERM_NO};
    access_map[CMD_RESUME]       = '{PERM_NO, PERM_OK, PERM_NO, PERM_NO, PERM_NO, PERM_NO, PERM_NO};
    access_map[CMD_RESET_FAULT]  = '{PERM_NO, PERM_IF, PERM_NO, PERM_NO, PERM_NO, PERM_IF, PERM_NO};
    access_map[CMD_HOME]         = '{PERM_NO, PERM_NO, PERM_NO, PERM_NO, PERM_NO, PERM_OK, PERM_NO};
    access_map[CMD_ENTER_MANUAL] = '{PERM_NO, PERM_OK, PERM_NO, PERM_NO, PERM_NO, PERM_NO, PERM_NO};
    access_map[CMD_MANUAL_ACT]   = '{PERM_NO, PERM_NO, PERM_NO, PERM_OK, PERM_NO, PERM_OK, PERM_NO};
    access_map[CMD_SELF_CHECK]   = '{PERM_NO, PERM_IF, PERM_NO, PERM_NO, PERM_NO, PERM_IF, PERM_NO};
    access_map[CMD_RECOVER]      = '{PERM_NO, PERM_NO, PERM_NO, PERM_IF, PERM_NO, PERM_IF, PERM_NO};
    access_map[CMD_STOP_OUTPUTS] = '{PERM_NO, PERM_OK, PERM_OK, PERM_OK, PERM_NO, PERM_OK, PERM_OK};
    effect_of[CMD_START_WASH]    = EFF_START_WASH;
    effect_of[CMD_STOP_WASH]     = EFF_STOP_WASH;
    effect_of[CMD_STOP_OP]       = EFF_NONE;
    effect_of[CMD_RESUME]        = EFF_NONE;
    effect_of[CMD_RESET_FAULT]   = EFF_RESET_FAULT;
    effect_of[CMD_HOME]          = EFF_HOME;
    effect_of[CMD_ENTER_MANUAL]  = EFF_NONE;
    effect_of[CMD_MANUAL_ACT]    = EFF_MANUAL_ACT;
    effect_of[CMD_SELF_CHECK]    = EFF_SELF_CHECK;
    effect_of[CMD_RECOVER]       = EFF_NONE;
    effect_of[CMD_STOP_OUTPUTS]  = EFF_STOP_OUTPUTS;
  end

  function automatic reason_t command_verdict(input logic [3:0] kind, input logic blk,
                                              input logic lock);
    perm_t level;
    if (kind == 4'd0 || kind > CMD_STOP_OUTPUTS) return RSN_UNKNOWN_CMD;
    level = access_map[kind][gate_mode];
    if (level == PERM_NO) return RSN_WRONG_MODE;
    if (level == PERM_IF && estop_on) return RSN_ESTOP;
    // A fault reset from idle needs something to clear.
    if (kind == CMD_RESET_FAULT && gate_mode == MODE_IDLE && !blk && !lock)
      return RSN_WRONG_MODE;
    if (kind == CMD_START_WASH) begin
      if (!service_en) return RSN_SERVICE_OFF;
      if (blk) return RSN_WRONG_MODE;
    end
    if (kind == CMD_RESUME && service_en) return RSN_WRONG_MODE;
    return RSN_NONE;
  endfunction

  task automatic predict_outcome(input logic [3:0] op, input logic [3:0] kind,
                                 input logic flag, input logic blk, input logic lock,
                                 output result_t res);
    mode_t   start_mode;
    mode_t   next_mode;
    logic    direct_load;
    reason_t why;
    res = '0;
    start_mode = gate_mode;
    next_mode = gate_mode;
    direct_load = 1'b0;
    case (op)
      OP_COMMAND: begin
        why = command_verdict(kind, blk, lock);
        if (why != RSN_NONE) begin
          res.cmd_rejected = 1'b1;
          res.reject_reason = why;
        end else begin
          res.effect_code = effect_of[kind];
          case (kind)
            CMD_ENTER_MANUAL: next_mode = MODE_MANUAL;
            CMD_SELF_CHECK:   next_mode = MODE_SELFCHECK;
            CMD_RECOVER: begin
              next_mode = MODE_RECOVERING;
              res.recovery_requested = 1'b1;
            end
            CMD_STOP_OP: begin
              service_en = 1'b0;
              res.context_sync = 1'b1;
            end
            CMD_RESUME: begin
              service_en = 1'b1;
              res.context_sync = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_INIT: begin
        next_mode = MODE_IDLE;
        estop_on = 1'b0;
        service_en = 1'b1;
        direct_load = 1'b1;
      end
      OP_WASH_START:
        if (gate_mode == MODE_IDLE) next_mode = MODE_WASHING;
      OP_WASH_DONE:
        if (gate_mode == MODE_WASHING) next_mode = MODE_IDLE;
      OP_WASH_ABORT:
        if (gate_mode == MODE_WASHING) next_mode = flag ? MODE_IDLE : MODE_EXCEPTION;
      OP_POST_WASH:
        if (gate_mode == MODE_IDLE && flag) next_mode = MODE_EXCEPTION;
      OP_SELFCHECK_DONE:
        if (gate_mode == MODE_SELFCHECK) next_mode = flag ? MODE_EXCEPTION : MODE_IDLE;
      OP_CRITICAL:
        if (gate_mode != MODE_WASHING && gate_mode != MODE_RECOVERING)
          next_mode = MODE_EXCEPTION;
      OP_ESTOP_ON: begin
        estop_on = 1'b1;
        next_mode = MODE_EXCEPTION;
      end
      OP_ESTOP_OFF: begin
        estop_on = 1'b0;
        res.context_sync = 1'b1;
      end
      OP_RECOVERY_DONE:
        if (gate_mode == MODE_RECOVERING) next_mode = flag ? MODE_IDLE : MODE_EXCEPTION;
      OP_LEGACY_RESET:
        if (gate_mode == MODE_EXCEPTION) next_mode = MODE_IDLE;
      OP_SET_SERVICE: begin
        service_en = flag;
        res.context_sync = 1'b1;
      end
      default: ;
    endcase
    res.mode_changed = !direct_load && (next_mode != start_mode);
    gate_mode = next_mode;
    res.mode_now = gate_mode;
    res.mode_before = start_mode;
    res.estop_latched = estop_on;
    res.service_on = service_en;
    res.stopping = !service_en || gate_mode == MODE_INIT || gate_mode == MODE_EXCEPTION ||
                   gate_mode == MODE_RECOVERING;
    res.standby = gate_mode == MODE_IDLE && service_en;
  endtask

  task automatic report_mismatch(input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t result mismatch: expected rej=%0d rsn=%0d eff=%0d now=%0d was=%0d flags=%b,",
               $realtime, want.cmd_rejected, want.reject_reason, want.effect_code,
               want.mode_now, want.mode_before,
               {want.mode_changed, want.recovery_requested, want.context_sync,
                want.estop_latched, want.service_on, want.stopping, want.standby},
               " got rej=%0d rsn=%0d eff=%0d now=%0d was=%0d flags=%b",
               got.cmd_rejected, got.reject_reason, got.effect_code,
               got.mode_now, got.mode_before,
               {got.mode_changed, got.recovery_requested, got.context_sync,
                got.estop_latched, got.service_on, got.stopping, got.standby});
  endtask

  always @(posedge clk) begin
    result_t fresh;
    result_t got;
    result_t want;
    if (rst) begin
      gate_mode = MODE_INIT;
      estop_on = 1'b0;
      service_en = 1'b1;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_outcome(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[4], s_axis_tdata[5],
                        s_axis_tdata[6], fresh);
        expected_results.push_back(fresh);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.cmd_rejected       = m_axis_tdata[0];
        got.reject_reason      = reason_t'(m_axis_tdata[3:1]);
        got.effect_code        = effect_t'(m_axis_tdata[6:4]);
        got.mode_now           = mode_t'(m_axis_tdata[9:7]);
        got.mode_before        = mode_t'(m_axis_tdata[12:10]);
        got.mode_changed       = m_axis_tdata[13];
        got.recovery_requested = m_axis_tdata[14];
        got.context_sync       = m_axis_tdata[15];
        got.estop_latched      = m_axis_tdata[16];
        got.service_on         = m_axis_tdata[17];
        got.stopping           = m_axis_tdata[18];
        got.standby            = m_axis_tdata[19];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t result item arrived with no prediction waiting: tdata=%h",
                     $realtime, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.cmd_rejected !== want.cmd_rejected ||
              got.reject_reason !== want.reject_reason ||
              got.effect_code !== want.effect_code ||
              got.mode_now !== want.mode_now ||
              got.mode_before !== want.mode_before ||
              got.mode_changed !== want.mode_changed ||
              got.recovery_requested !== want.recovery_requested ||
              got.context_sync !== want.context_sync ||
              got.estop_latched !== want.estop_latched ||
              got.service_on !== want.service_on ||
              got.stopping !== want.stopping ||
              got.standby !== want.standby)
            report_mismatch(want, got);
        end
      end
    end
    awaiting = expected_results.size();
  end

endmodule

>>> sim/tb_operating_mode_command_gate.sv
`timescale 1ns / 1ps

module tb_operating_mode_command_gate;
  import omcg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 290;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int mismatches;
  int awaiting;
  int sent_items = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  operating_mode_command_gate dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  omcg_result_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_count (mismatches),
    .awaiting       (awaiting)
  );

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_operating_mode_command_gate failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves tvalid high after the handshake so back-to-back items need no extra edge.
  task automatic send_item(input logic [3:0] op, input logic [3:0] kind, input logic flag,
                           input logic blk, input logic lock);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, lock, blk, flag, kind};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_command(input cmd_t kind, input logic blk, input logic lock);
    send_item(OP_COMMAND, kind, 1'b0, blk, lock);
  endtask

  task automatic send_event(input op_t op, input logic flag);
    send_item(op, 4'($urandom_range(15)), flag, 1'($urandom_range(1)),
              1'($urandom_range(1)));
  endtask

  task automatic send_random_item;
    int          pick;
    logic [3:0]  op;
    logic [3:0]  kind;
    logic        flag;
    pick = $urandom_range(99);
    kind = 4'($urandom_range(15));
    flag = 1'($urandom_range(1));
    if (pick < 4) begin
      op = 4'($urandom_range(15, 13));
    end else if (pick < 50) begin
      op = OP_COMMAND;
      if ($urandom_range(9) == 0) kind = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 12));
      else kind = 4'($urandom_range(11, 1));
    end else begin
      op = 4'($urandom_range(12, 1));
      // Keep service mostly enabled so commands get past the service rules.
      if (op == OP_SET_SERVICE) flag = ($urandom_range(9) < 7);
    end
    send_item(op, kind, flag, $urandom_range(3) == 0, $urandom_range(3) == 0);
  endtask

  // Short well-formed sequences that walk the mode through its normal paths.
  task automatic send_flow;
    case ($urandom_range(3))
      0: begin
        send_event(OP_INIT, 1'b0);
        send_command(CMD_START_WASH, $urandom_range(4) == 0, 1'($urandom_range(1)));
        send_event(OP_WASH_START, 1'b0);
        send_command(CMD_STOP_WASH, 1'b0, 1'b0);
        if ($urandom_range(1)) send_event(OP_WASH_DONE, 1'b0);
        else send_event(OP_WASH_ABORT, 1'($urandom_range(1)));
      end
      1: begin
        send_event(OP_INIT, 1'b0);
        send_command(CMD_SELF_CHECK, 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_event(OP_SELFCHECK_DONE, 1'($urandom_range(1)));
      end
      2: begin
        send_event(($urandom_range(3) == 0) ? OP_ESTOP_ON : OP_CRITICAL, 1'b0);
        send_command(CMD_RESET_FAULT, 1'($urandom_range(1)), 1'($urandom_range(1)));
        if ($urandom_range(1)) send_event(OP_ESTOP_OFF, 1'b0);
        send_command(CMD_RECOVER, 1'b0, 1'b0);
        send_event(OP_RECOVERY_DONE, 1'($urandom_range(1)));
      end
      default: begin
        send_event(OP_INIT, 1'b0);
        send_command(CMD_ENTER_MANUAL, 1'b0, 1'b0);
        send_command(CMD_MANUAL_ACT, 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_command(($urandom_range(1) == 0) ? CMD_RECOVER : CMD_STOP_OUTPUTS, 1'b0, 1'b0);
      end
    endcase
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, starting from the init mode.
    send_command(CMD_START_WASH, 1'b0, 1'b0);
    send_item(OP_COMMAND, 4'd0, 1'b0, 1'b0, 1'b0);
    send_item(OP_COMMAND, 4'd15, 1'b1, 1'b1, 1'b1);
    send_item(4'd13, 4'd5, 1'b1, 1'b1, 1'b1);
    send_item(4'd15, 4'd15, 1'b1, 1'b1, 1'b1);
    send_event(OP_INIT, 1'b0);
    send_command(CMD_RESET_FAULT, 1'b0, 1'b0);
    send_command(CMD_RESET_FAULT, 1'b1, 1'b0);
    send_command(CMD_START_WASH, 1'b1, 1'b0);
    send_command(CMD_RESUME, 1'b0, 1'b0);
    send_command(CMD_STOP_OP, 1'b0, 1'b0);
    send_command(CMD_START_WASH, 1'b0, 1'b0);
    send_command(CMD_RESUME, 1'b0, 1'b0);
    send_command(CMD_START_WASH, 1'b0, 1'b1);
    send_event(OP_WASH_START, 1'b0);
    send_command(CMD_STOP_WASH, 1'b0, 1'b0);
    send_event(OP_WASH_ABORT, 1'b0);
    send_event(OP_ESTOP_ON, 1'b0);
    send_command(CMD_SELF_CHECK, 1'b0, 1'b0);
    send_event(OP_ESTOP_OFF, 1'b0);
    send_command(CMD_HOME, 1'b0, 1'b0);
    send_command(CMD_RECOVER, 1'b0, 1'b0);
    send_event(OP_CRITICAL, 1'b0);
    send_event(OP_RECOVERY_DONE, 1'b1);
    send_item(OP_SET_SERVICE, 4'd11, 1'b0, 1'b0, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      target = sent_items + ITEMS_PER_PHASE;
      while (sent_items < target) begin
        if ($urandom_range(99) < 30) send_flow();
        else send_random_item();
      end
    end
    s_axis_tvalid <= 1'b0;

    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_operating_mode_command_gate passed");
    end else begin
      $display("tb_operating_mode_command_gate failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/omcg_pkg.sv
design/omcg_step.sv
design/operating_mode_command_gate.sv
sim/omcg_result_checker.sv
sim/tb_operating_mode_command_gate.sv
